@@ hw/rtl/dpg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpg_pkg
// Widths and stage counts shared by the distance panning gain pipeline.
// ----------------------------------------------------------------------------
package dpg_pkg;

    // Field widths of one transfer.
    localparam int unsigned PosW   = 16;
    localparam int unsigned GainW  = 16;

    // Square root: 32 result bits, one per stage.
    localparam int unsigned SqrtSteps = 32;
    localparam int unsigned RadW      = 64;
    localparam int unsigned SqRemW    = 34;

    // Division: 17 quotient bits, one per stage.
    localparam int unsigned DivSteps = 17;
    localparam int unsigned DenW     = 31;
    localparam int unsigned NumW     = 48;

    // Pipeline depth: front (2) + root (33) + diff (1) + div (18) + output (1).
    localparam int unsigned Stages = 2 + SqrtSteps + 1 + 1 + DivSteps + 1 + 1;

endpackage

@@ hw/rtl/distance_panning_gain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_panning_gain
// Speaker gain from source and speaker positions, radius and level.
// ----------------------------------------------------------------------------
// Usage: each slave-side transfer carries one source/speaker pair; each
// master-side transfer carries the gain for it, in the same order.
// Gain is |1 - d/radius| * level in Q1.15, saturated; out of reach (an axis
// distance above the radius, or a zero radius) gives gain 0 and the flag set.
// Throughput is one pair per cycle while m_tready does not hold the output.
// The pipeline has 55 register stages: the result moves through all of them
// into the output register, where it can be taken. The depth is set by the
// 32-stage square root and the 17-stage divider, one result bit per stage.
// The whole pipeline moves as one: when the output holds an untaken result
// and m_tready is low, every stage holds and s_tready drops, so nothing is
// lost or repeated. Bubbles travel as cleared valid bits.
// Reset (aresetn low at a clock edge) clears all valid bits; payload
// registers are not reset.
// ----------------------------------------------------------------------------
module distance_panning_gain (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // source_x, source_y, speaker_x, speaker_y, speaker_radius, speaker_level
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // gain
    output logic [15:0] m_tdata,
    // out_of_reach
    output logic [0:0]  m_tuser
);

    localparam int unsigned SQ = dpg_pkg::SqrtSteps;
    localparam int unsigned DV = dpg_pkg::DivSteps;
    localparam int unsigned NS = dpg_pkg::Stages;

    logic adv;
    logic [NS-1:0] valid_reg, valid_next;

    // Front stage registers.
    logic [16:0] dx_reg, dy_reg;
    logic [15:0] f_r_reg, f_lvl_reg;
    logic        f_oor_reg;
    logic [33:0] dx2_reg, dy2_reg;
    logic [15:0] m_r_reg, m_lvl_reg;
    logic        m_oor_reg;

    // Square root stages.
    logic [dpg_pkg::RadW-1:0]   sq_rad_reg  [0:SQ];
    logic [dpg_pkg::SqRemW-1:0] sq_rem_reg  [0:SQ];
    logic [31:0]                sq_root_reg [0:SQ];
    logic [15:0]                sq_r_reg    [0:SQ];
    logic [15:0]                sq_lvl_reg  [0:SQ];
    logic                       sq_oor_reg  [0:SQ];
    logic [dpg_pkg::RadW-1:0]   sq_rad_next  [1:SQ];
    logic [dpg_pkg::SqRemW-1:0] sq_rem_next  [1:SQ];
    logic [31:0]                sq_root_next [1:SQ];
    logic [35:0]                sq_try [0:SQ-1];
    logic [35:0]                sq_sub [0:SQ-1];

    // Difference stage.
    logic [31:0] diff_reg;
    logic [15:0] d_lvl_reg;
    logic [15:0] d_r_reg;
    logic        d_oor_reg;

    // Divider stages.
    logic [dpg_pkg::DenW-1:0] dv_den_reg [0:DV];
    logic [dpg_pkg::DenW-1:0] dv_rem_reg [0:DV];
    logic [16:0]              dv_low_reg [0:DV];
    logic [16:0]              dv_quo_reg [0:DV];
    logic                     dv_oor_reg [0:DV];
    logic [dpg_pkg::DenW-1:0] dv_rem_next [1:DV];
    logic [16:0]              dv_low_next [1:DV];
    logic [16:0]              dv_quo_next [1:DV];
    logic [31:0]              dv_try [0:DV-1];

    // Output register.
    logic [15:0] gain_reg;
    logic        oor_reg;

    // Input field views.
    logic signed [15:0] src_x, src_y, spk_x, spk_y;
    logic [15:0] in_r, in_lvl;
    logic [16:0] dx_next, dy_next;
    logic [30:0] rs;
    logic [31:0] q_fin;
    logic [47:0] num;

    assign src_x  = s_tdata[15:0];
    assign src_y  = s_tdata[31:16];
    assign spk_x  = s_tdata[47:32];
    assign spk_y  = s_tdata[63:48];
    assign in_r   = s_tdata[79:64];
    assign in_lvl = s_tdata[95:80];

    // The pipeline advances unless the output holds an untaken result.
    assign adv        = !valid_reg[NS-1] || m_tready;
    assign s_tready   = adv;
    assign valid_next = {valid_reg[NS-2:0], s_tvalid};

    // Absolute axis distances.
    always_comb begin
        logic signed [16:0] ex, ey;
        ex = 17'(spk_x) - 17'(src_x);
        ey = 17'(spk_y) - 17'(src_y);
        dx_next = ex[16] ? 17'(-ex) : 17'(ex);
        dy_next = ey[16] ? 17'(-ey) : 17'(ey);
    end

    // One root bit per stage, restoring digit-by-digit method.
    always_comb begin
        for (int j = 0; j < SQ; j++) begin
            sq_try[j] = {sq_rem_reg[j], sq_rad_reg[j][63:62]};
            sq_sub[j] = {2'b00, sq_root_reg[j], 2'b01};
            sq_rad_next[j+1] = {sq_rad_reg[j][61:0], 2'b00};
            if (sq_try[j] >= sq_sub[j]) begin
                sq_rem_next[j+1]  = 34'(sq_try[j] - sq_sub[j]);
                sq_root_next[j+1] = {sq_root_reg[j][30:0], 1'b1};
            end else begin
                sq_rem_next[j+1]  = sq_try[j][33:0];
                sq_root_next[j+1] = {sq_root_reg[j][30:0], 1'b0};
            end
        end
    end

    // Scaled radius against distance.
    assign rs    = {d_r_reg[15:0], 15'd0};
    assign q_fin = sq_root_reg[SQ];

    // Product of difference and level feeds the divider.
    assign num = diff_reg * d_lvl_reg;

    // One quotient bit per stage, restoring division.
    always_comb begin
        for (int k = 0; k < DV; k++) begin
            dv_try[k] = {dv_rem_reg[k], dv_low_reg[k][16]};
            dv_low_next[k+1] = {dv_low_reg[k][15:0], 1'b0};
            if (dv_try[k] >= {1'b0, dv_den_reg[k]}) begin
                dv_rem_next[k+1] = 31'(dv_try[k] - {1'b0, dv_den_reg[k]});
                dv_quo_next[k+1] = {dv_quo_reg[k][15:0], 1'b1};
            end else begin
                dv_rem_next[k+1] = dv_try[k][30:0];
                dv_quo_next[k+1] = {dv_quo_reg[k][15:0], 1'b0};
            end
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    // Payload stages, all moving together.
    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            f_r_reg   <= in_r;
            f_lvl_reg <= in_lvl;
            f_oor_reg <= (in_r == 16'd0) || (dx_next > {1'b0, in_r})
                         || (dy_next > {1'b0, in_r});

            dx2_reg   <= dx_reg * dx_reg;
            dy2_reg   <= dy_reg * dy_reg;
            m_r_reg   <= f_r_reg;
            m_lvl_reg <= f_lvl_reg;
            m_oor_reg <= f_oor_reg;

            // Radicand is the squared distance scaled by 2^30.
            sq_rad_reg[0]  <= {34'(35'(dx2_reg) + 35'(dy2_reg)), 30'd0};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_r_reg[0]    <= m_r_reg;
            sq_lvl_reg[0]  <= m_lvl_reg;
            sq_oor_reg[0]  <= m_oor_reg;
            for (int j = 1; j <= SQ; j++) begin
                sq_rad_reg[j]  <= sq_rad_next[j];
                sq_rem_reg[j]  <= sq_rem_next[j];
                sq_root_reg[j] <= sq_root_next[j];
                sq_r_reg[j]    <= sq_r_reg[j-1];
                sq_lvl_reg[j]  <= sq_lvl_reg[j-1];
                sq_oor_reg[j]  <= sq_oor_reg[j-1];
            end

            diff_reg  <= ({1'b0, sq_r_reg[SQ], 15'd0} > q_fin)
                         ? 32'({1'b0, sq_r_reg[SQ], 15'd0} - q_fin)
                         : 32'(q_fin - {1'b0, sq_r_reg[SQ], 15'd0});
            d_lvl_reg <= sq_lvl_reg[SQ];
            d_r_reg   <= sq_r_reg[SQ];
            d_oor_reg <= sq_oor_reg[SQ];

            dv_den_reg[0] <= rs;
            dv_rem_reg[0] <= num[47:17];
            dv_low_reg[0] <= num[16:0];
            dv_quo_reg[0] <= '0;
            dv_oor_reg[0] <= d_oor_reg;
            for (int k = 1; k <= DV; k++) begin
                dv_den_reg[k] <= dv_den_reg[k-1];
                dv_rem_reg[k] <= dv_rem_next[k];
                dv_low_reg[k] <= dv_low_next[k];
                dv_quo_reg[k] <= dv_quo_next[k];
                dv_oor_reg[k] <= dv_oor_reg[k-1];
            end

            oor_reg  <= dv_oor_reg[DV];
            gain_reg <= dv_oor_reg[DV] ? 16'd0
                        : (dv_quo_reg[DV][16] ? 16'hFFFF : dv_quo_reg[DV][15:0]);
        end
    end

    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = gain_reg;
    assign m_tuser  = oor_reg;

endmodule
